// ----- rtl/fragment_hole_reassembly_core_assert.svh -----
// Assertion macros shared by the reassembly core modules
`ifndef FRAGMENT_HOLE_REASSEMBLY_CORE_ASSERT_SVH
`define FRAGMENT_HOLE_REASSEMBLY_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FHR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FHR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fhr_pkg.sv -----
// Shared types and constants of the fragment reassembly core
`default_nettype none
package fhr_pkg;

  localparam int unsigned DEF_PACKET_SLOTS = 8;
  localparam int unsigned DEF_MAX_HOLES    = 8;
  localparam int unsigned DEF_BUFFER_BYTES = 2048;
  localparam int unsigned DEF_QUEUE_DEPTH  = 2;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [10:0] POS_MAX    = 11'd2047;

  typedef enum logic [1:0] {
    FUNC_FRAG    = 2'd0,
    FUNC_QUERY   = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_SLOT  = 2'd1,
    ERR_HOLE_OVF = 2'd2
  } err_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] packet_id;
    logic [10:0] frag_offset;
    logic [11:0] frag_length;
    logic        more_follow;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [10:0] read_index;
    logic [11:0] pos;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/fhr_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module fhr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/fhr_front.sv -----
// Input side: accepts beats, unpacks fields and tracks the byte position
`default_nettype none
module fhr_front
  import fhr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output      logic                 s_ready_o,
  input  wire logic [IN_DATA_W-1:0] s_data_i,
  input  wire logic [1:0]           s_user_i,
  input  wire logic                 s_last_i,
  input  wire logic                 q_full_i,
  output      logic                 q_push_o,
  output      item_t                q_item_o
);

  logic [10:0] bpos_q, bpos_d;
  logic        acc;

  assign s_ready_o = !q_full_i;
  assign acc       = s_valid_i && !q_full_i;
  assign q_push_o  = acc;

  always_comb begin
    q_item_o.func        = func_e'(s_user_i);
    q_item_o.packet_id   = s_data_i[31:0];
    q_item_o.frag_offset = s_data_i[42:32];
    q_item_o.frag_length = s_data_i[54:43];
    q_item_o.more_follow = s_data_i[55];
    q_item_o.data_byte   = s_data_i[63:56];
    q_item_o.last_byte   = s_last_i;
    q_item_o.read_index  = s_data_i[74:64];
    q_item_o.pos         = 12'(s_data_i[42:32]) + 12'(bpos_q);
  end

  // clear on a fragment's last byte, else saturate upward
  always_comb begin
    bpos_d = bpos_q;
    if (acc && func_e'(s_user_i) == FUNC_FRAG) begin
      if (s_last_i) begin
        bpos_d = '0;
      end else if (bpos_q < POS_MAX) begin
        bpos_d = bpos_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= '0;
    end else begin
      bpos_q <= bpos_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fhr_queue.sv -----
// Short FIFO between the front and back parts
`default_nettype none
module fhr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  output      logic             valid_o,
  output      logic [WIDTH-1:0] data_o,
  input  wire logic             pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fhr_back.sv -----
// Execution side: slot table, hole list walk, byte buffer and result register
`default_nettype none
`include "fragment_hole_reassembly_core_assert.svh"
module fhr_back
  import fhr_pkg::*;
#(
  parameter int unsigned PACKET_SLOTS = DEF_PACKET_SLOTS,
  parameter int unsigned MAX_HOLES    = DEF_MAX_HOLES,
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire item_t       q_item_i,
  output      logic        q_pop_o,
  output      logic        m_valid_o,
  input  wire logic        m_ready_i,
  output      logic        found_o,
  output      logic        ready_res_o,
  output      logic [7:0]  data_out_o,
  output      logic [1:0]  error_code_o
);

  localparam int unsigned SW     = (PACKET_SLOTS > 1) ? $clog2(PACKET_SLOTS) : 1;
  localparam int unsigned HCW    = $clog2(MAX_HOLES + 1);
  localparam int unsigned HIW    = $clog2(MAX_HOLES);
  localparam int unsigned NW     = $clog2(2 * MAX_HOLES + 1);
  localparam int unsigned PW     = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CW     = (PW > 13) ? PW : 13;
  localparam int unsigned HDEPTH = 2 * PACKET_SLOTS * MAX_HOLES;
  localparam int unsigned HAW    = $clog2(HDEPTH);
  localparam int unsigned BDEPTH = PACKET_SLOTS * BUFFER_BYTES;
  localparam int unsigned BAW    = $clog2(BDEPTH);
  localparam int unsigned CCW    = $clog2(BUFFER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_WRB, S_RDB, S_RDD, S_HRD, S_HPR, S_HTL, S_HCM, S_RES
  } state_e;

  state_e         state_q;
  item_t          item_q;
  logic [SW-1:0]  slot_q;
  logic           found_q;
  err_e           err_q;
  logic [7:0]     dout_q;
  logic [CCW-1:0] clr_q;
  logic [HIW-1:0] h_q;
  logic [HCW-1:0] cnt_q;
  logic [NW-1:0]  n_q;
  logic           pass_q;
  logic [PW-1:0]  he_q;
  logic [CW-1:0]  first_q, last_q;

  logic           valid_q [PACKET_SLOTS];
  logic [31:0]    id_q    [PACKET_SLOTS];
  logic [HCW-1:0] hcnt_q  [PACKET_SLOTS];
  logic           bank_q  [PACKET_SLOTS];

  logic           m_valid_q, m_found_q, m_ready_q;
  logic [7:0]     m_dout_q;
  err_e           m_err_q;

  logic           hit, free_ok;
  logic [SW-1:0]  hit_idx, free_idx;

  logic            h_we;
  logic [HAW-1:0]  h_waddr, h_raddr;
  logic [2*PW-1:0] h_wdata, h_rdata;
  logic            b_we;
  logic [BAW-1:0]  b_waddr, b_raddr;
  logic [7:0]      b_wdata, b_rdata;

  logic [CW-1:0]   hs_w, he_w;
  logic            ov_w, front_w, tail_w, app_w, last_h;
  logic            pos_ok, ridx_ok;

  function automatic logic [HAW-1:0] haddr(input logic b, input logic [SW-1:0] s,
                                           input logic [HIW-1:0] i);
    return HAW'((32'(b) * PACKET_SLOTS + 32'(s)) * MAX_HOLES + 32'(i));
  endfunction

  function automatic logic [BAW-1:0] baddr(input logic [SW-1:0] s, input logic [31:0] p);
    return BAW'(32'(s) * BUFFER_BYTES + p);
  endfunction

  // lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = PACKET_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && id_q[i] == q_item_i.packet_id) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign pos_ok  = 32'(item_q.pos) < BUFFER_BYTES;
  assign ridx_ok = 32'(q_item_i.read_index) < BUFFER_BYTES;

  assign hs_w    = CW'(h_rdata[2*PW-1:PW]);
  assign he_w    = CW'(h_rdata[PW-1:0]);
  assign ov_w    = !((first_q > he_w) || (last_q < hs_w));
  assign front_w = first_q > hs_w;
  assign app_w   = pass_q ? (ov_w && front_w) : !ov_w;
  assign tail_w  = pass_q && ov_w && (last_q < he_w) && item_q.more_follow;
  assign last_h  = (HCW'(h_q) + HCW'(1)) == cnt_q;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // hole RAM: the live list sits in bank_q, the rebuilt list goes to the other bank
  always_comb begin
    h_we    = 1'b0;
    h_waddr = haddr(!bank_q[slot_q], slot_q, n_q[HIW-1:0]);
    h_wdata = {PW'(hs_w), PW'(he_w)};
    h_raddr = haddr(bank_q[slot_q], slot_q, h_q);
    case (state_q)
      S_IDLE: begin
        h_waddr = haddr(bank_q[free_idx], free_idx, '0);
        h_wdata = {PW'(0), PW'(BUFFER_BYTES)};
        h_we    = q_valid_i && q_item_i.func == FUNC_FRAG && !hit && free_ok;
      end
      S_HPR: begin
        h_we = app_w && (n_q < NW'(MAX_HOLES));
        if (pass_q) begin
          h_wdata = {PW'(hs_w), PW'(first_q - CW'(1))};
        end
      end
      S_HTL: begin
        h_we    = n_q < NW'(MAX_HOLES);
        h_wdata = {PW'(last_q + CW'(1)), he_q};
      end
      default: begin
        h_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = baddr(slot_q, 32'(item_q.pos));
    b_wdata = item_q.data_byte;
    b_raddr = baddr(slot_q, 32'(item_q.read_index));
    case (state_q)
      S_CLR: begin
        b_we    = 1'b1;
        b_waddr = baddr(slot_q, 32'(clr_q));
        b_wdata = '0;
      end
      S_WRB: begin
        b_we = pos_ok;
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  fhr_ram #(.WIDTH(2 * PW), .DEPTH(HDEPTH)) u_hole_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  fhr_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      slot_q    <= '0;
      found_q   <= 1'b0;
      err_q     <= ERR_OK;
      dout_q    <= '0;
      clr_q     <= '0;
      h_q       <= '0;
      cnt_q     <= '0;
      n_q       <= '0;
      pass_q    <= 1'b0;
      he_q      <= '0;
      first_q   <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
      m_found_q <= 1'b0;
      m_ready_q <= 1'b0;
      m_dout_q  <= '0;
      m_err_q   <= ERR_OK;
      for (int i = 0; i < PACKET_SLOTS; i++) begin
        valid_q[i] <= 1'b0;
        id_q[i]    <= '0;
        hcnt_q[i]  <= '0;
        bank_q[i]  <= 1'b0;
      end
    end else begin
      if (m_ready_i && state_q != S_RES) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            item_q <= q_item_i;
            err_q  <= (q_item_i.func == FUNC_FRAG && !hit && !free_ok) ? ERR_NO_SLOT : ERR_OK;
            dout_q <= '0;
            if (q_item_i.func == FUNC_FRAG && !hit && free_ok) begin
              // open the slot, then zero its buffer
              slot_q            <= free_idx;
              found_q           <= 1'b1;
              valid_q[free_idx] <= 1'b1;
              id_q[free_idx]    <= q_item_i.packet_id;
              hcnt_q[free_idx]  <= HCW'(1);
              clr_q             <= '0;
              state_q           <= S_CLR;
            end else begin
              slot_q  <= hit_idx;
              found_q <= hit;
              case (q_item_i.func)
                FUNC_FRAG: begin
                  state_q <= hit ? S_WRB : S_RES;
                end
                FUNC_READ: begin
                  state_q <= (hit && ridx_ok) ? S_RDB : S_RES;
                end
                FUNC_RELEASE: begin
                  if (hit) begin
                    valid_q[hit_idx] <= 1'b0;
                    hcnt_q[hit_idx]  <= '0;
                  end
                  state_q <= S_RES;
                end
                default: begin
                  state_q <= S_RES;
                end
              endcase
            end
          end
        end
        S_CLR: begin
          clr_q <= clr_q + CCW'(1);
          if (clr_q == CCW'(BUFFER_BYTES - 1)) begin
            state_q <= S_WRB;
          end
        end
        S_WRB: begin
          if (item_q.last_byte && item_q.frag_length != '0) begin
            first_q <= CW'(item_q.frag_offset);
            last_q  <= CW'(item_q.frag_offset) + CW'(item_q.frag_length) - CW'(1);
            pass_q  <= 1'b0;
            h_q     <= '0;
            n_q     <= '0;
            cnt_q   <= hcnt_q[slot_q];
            state_q <= (hcnt_q[slot_q] == '0) ? S_HCM : S_HRD;
          end else begin
            state_q <= S_RES;
          end
        end
        S_RDB: begin
          state_q <= S_RDD;
        end
        S_RDD: begin
          dout_q  <= b_rdata;
          state_q <= S_RES;
        end
        S_HRD: begin
          state_q <= S_HPR;
        end
        S_HPR: begin
          n_q <= n_q + NW'(app_w);
          if (tail_w) begin
            he_q    <= PW'(he_w);
            state_q <= S_HTL;
          end else if (!last_h) begin
            h_q     <= h_q + HIW'(1);
            state_q <= S_HRD;
          end else if (!pass_q) begin
            // kept holes done, now the split parts
            pass_q  <= 1'b1;
            h_q     <= '0;
            state_q <= S_HRD;
          end else begin
            state_q <= S_HCM;
          end
        end
        S_HTL: begin
          n_q <= n_q + NW'(1);
          if (!last_h) begin
            h_q     <= h_q + HIW'(1);
            state_q <= S_HRD;
          end else begin
            state_q <= S_HCM;
          end
        end
        S_HCM: begin
          bank_q[slot_q] <= !bank_q[slot_q];
          if (n_q > NW'(MAX_HOLES)) begin
            hcnt_q[slot_q] <= HCW'(MAX_HOLES);
            err_q          <= ERR_HOLE_OVF;
          end else begin
            hcnt_q[slot_q] <= HCW'(n_q);
          end
          state_q <= S_RES;
        end
        S_RES: begin
          if (!m_valid_q || m_ready_i) begin
            m_valid_q <= 1'b1;
            m_found_q <= found_q;
            m_ready_q <= found_q && item_q.func != FUNC_RELEASE && hcnt_q[slot_q] == '0;
            m_dout_q  <= dout_q;
            m_err_q   <= err_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_valid_o    = m_valid_q;
  assign found_o      = m_found_q;
  assign ready_res_o  = m_ready_q;
  assign data_out_o   = m_dout_q;
  assign error_code_o = m_err_q;

  `FHR_ASSERT_IMP(a_clr_slot_open, state_q == S_CLR, valid_q[slot_q], "clearing a closed slot")
  `FHR_ASSERT_IMP(a_walk_nonempty, state_q == S_HPR, cnt_q != '0, "hole walk on empty list")
  `FHR_ASSERT_NXT(a_pop_leaves_idle, q_pop_o, state_q != S_IDLE, "popped item not taken")
  `FHR_ASSERT_IMP(a_noslot_not_found, state_q == S_RES && err_q == ERR_NO_SLOT, !found_q,
                  "dropped byte reported as found")

endmodule
`default_nettype wire

// ----- rtl/fragment_hole_reassembly_core.sv -----
// Each item passes the input queue and is then run by the back end one at a time: a query, a
// release or a missed id goes from IDLE to RES; a byte of an open packet also passes WRB, an
// in-range read passes RDB and RDD. A packet's first byte first zeroes its BUFFER_BYTES-byte
// buffer in CLR. A fragment's last byte walks the hole list twice, HRD and HPR per hole a
// pass, plus HTL per tail split and HCM to commit the new list; the result is registered.
// Reset is asynchronous active low; it empties the slot table and queue, no clearing pass runs.
`default_nettype none
module fragment_hole_reassembly_core
  import fhr_pkg::*;
#(
  parameter int unsigned PACKET_SLOTS = DEF_PACKET_SLOTS,
  parameter int unsigned MAX_HOLES    = DEF_MAX_HOLES,
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // packet_id, frag_offset, frag_length, more flag, data_byte, read_index, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // found, ready_res, data_out, error_code, zero pad
  output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

  item_t      push_item, q_item;
  logic       q_push, q_full, q_valid, q_pop;
  logic       found, ready_res;
  logic [7:0] data_out;
  logic [1:0] error_code;

  fhr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (push_item)
  );

  fhr_queue #(.WIDTH($bits(item_t)), .DEPTH(DEF_QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_item),
    .pop_i   (q_pop)
  );

  fhr_back #(
    .PACKET_SLOTS (PACKET_SLOTS),
    .MAX_HOLES    (MAX_HOLES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .found_o      (found),
    .ready_res_o  (ready_res),
    .data_out_o   (data_out),
    .error_code_o (error_code)
  );

  assign m_axis_tdata = {4'b0000, error_code, data_out, ready_res, found};

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the fragment hole-list reassembly core: directed and random beats, scoreboard check
`timescale 1ns / 1ps

class reasm_scoreboard;
  localparam int unsigned SLOTS = fhr_pkg::DEF_PACKET_SLOTS;
  localparam int unsigned HOLES = fhr_pkg::DEF_MAX_HOLES;
  localparam int unsigned BUF   = fhr_pkg::DEF_BUFFER_BYTES;

  bit              slot_open [SLOTS];
  bit [31:0]       slot_id   [SLOTS];
  int unsigned     n_holes   [SLOTS];
  int unsigned     hole_lo   [SLOTS*HOLES];
  int unsigned     hole_hi   [SLOTS*HOLES];
  bit [7:0]        payload   [SLOTS*BUF];
  int unsigned     byte_pos;
  bit [15:0]       expected_beats[$];
  int              errors;
  int              n_ready, n_ovf, n_full, n_checked;

  function new();
    foreach (slot_open[i]) begin
      slot_open[i] = 0;
      n_holes[i] = 0;
    end
    foreach (payload[i]) payload[i] = '0;
    byte_pos = 0;
    errors = 0;
  endfunction

  function int lookup(bit [31:0] id);
    for (int s = 0; s < SLOTS; s++)
      if (slot_open[s] && slot_id[s] == id) return s;
    return -1;
  endfunction

  // remove holes hit by [first,last]; return 1 on hole overflow
  function bit punch_holes(int s, int unsigned first, int unsigned last, bit more);
    int unsigned ns[2*HOLES];
    int unsigned ne[2*HOLES];
    int unsigned n, b, cnt, hs, he;
    bit over;
    n = 0;
    over = 0;
    b = s * HOLES;
    cnt = n_holes[s];
    for (int h = 0; h < cnt; h++) begin
      hs = hole_lo[b+h];
      he = hole_hi[b+h];
      if (first > he || last < hs) begin
        ns[n] = hs; ne[n] = he; n++;
      end
    end
    for (int h = 0; h < cnt; h++) begin
      hs = hole_lo[b+h];
      he = hole_hi[b+h];
      if (!(first > he || last < hs)) begin
        if (first > hs) begin
          ns[n] = hs; ne[n] = first - 1; n++;
        end
        if (last < he && more) begin
          ns[n] = last + 1; ne[n] = he; n++;
        end
      end
    end
    if (n > HOLES) begin
      over = 1;
      n = HOLES;
    end
    for (int h = 0; h < n; h++) begin
      hole_lo[b+h] = ns[h];
      hole_hi[b+h] = ne[h];
    end
    n_holes[s] = n;
    return over;
  endfunction

  function void note_input(fhr_pkg::func_e fn, bit [79:0] d, bit lb);
    bit [31:0]   id;
    int unsigned off, len, ridx, pos;
    bit          more, found, rdy;
    bit [7:0]    db, dout;
    bit [15:0]   beat;
    fhr_pkg::err_e err;
    int          s, f;
    id   = d[31:0];
    off  = d[42:32];
    len  = d[54:43];
    more = d[55];
    db   = d[63:56];
    ridx = d[74:64];
    found = 0; rdy = 0; dout = '0; err = fhr_pkg::ERR_OK;
    s = lookup(id);
    if (fn == fhr_pkg::FUNC_FRAG) begin
      if (s < 0) begin
        f = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!slot_open[i]) f = i;
        if (f >= 0) begin
          s = f;
          slot_open[s] = 1;
          slot_id[s] = id;
          n_holes[s] = 1;
          hole_lo[s*HOLES] = 0;
          hole_hi[s*HOLES] = BUF;
          for (int i = 0; i < BUF; i++) payload[s*BUF+i] = '0;
        end else begin
          err = fhr_pkg::ERR_NO_SLOT;
        end
      end
      if (s >= 0) begin
        pos = off + byte_pos;
        if (pos < BUF) payload[s*BUF+pos] = db;
        if (lb && len != 0)
          if (punch_holes(s, off, off + len - 1, more)) err = fhr_pkg::ERR_HOLE_OVF;
        found = 1;
        rdy = (n_holes[s] == 0);
      end
      if (lb) byte_pos = 0;
      else if (byte_pos < 2047) byte_pos++;
    end else if (s >= 0) begin
      found = 1;
      if (fn == fhr_pkg::FUNC_RELEASE) begin
        slot_open[s] = 0;
        n_holes[s] = 0;
      end else begin
        rdy = (n_holes[s] == 0);
        if (fn == fhr_pkg::FUNC_READ && ridx < BUF) dout = payload[s*BUF+ridx];
      end
    end
    if (rdy) n_ready++;
    if (err == fhr_pkg::ERR_HOLE_OVF) n_ovf++;
    if (err == fhr_pkg::ERR_NO_SLOT) n_full++;
    beat = {4'b0, err, dout, rdy, found};
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  function void check_result(bit [15:0] act);
    bit [15:0] exp_beat;
    if (expected_beats.size() == 0) begin
      $display("%0t: result beat %h with nothing expected", $time, act);
      errors++;
      return;
    end
    exp_beat = expected_beats.pop_front();
    n_checked++;
    if (act[0] !== exp_beat[0]) begin
      $display("%0t: found exp %0d act %0d", $time, exp_beat[0], act[0]);
      errors++;
    end
    if (act[1] !== exp_beat[1]) begin
      $display("%0t: ready_res exp %0d act %0d", $time, exp_beat[1], act[1]);
      errors++;
    end
    if (act[9:2] !== exp_beat[9:2]) begin
      $display("%0t: data_out exp %h act %h", $time, exp_beat[9:2], act[9:2]);
      errors++;
    end
    if (act[11:10] !== exp_beat[11:10]) begin
      $display("%0t: error_code exp %0d act %0d", $time, exp_beat[11:10], act[11:10]);
      errors++;
    end
    if (act[15:12] !== exp_beat[15:12]) begin
      $display("%0t: pad exp %h act %h", $time, exp_beat[15:12], act[15:12]);
      errors++;
    end
  endfunction
endclass

module tb
  import fhr_pkg::*;
();

  localparam int STALL_LIMIT = 12000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = FUNC_QUERY;
  logic                  s_axis_tlast = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  reasm_scoreboard sb = new();
  int          in_beats = 0;
  int          idle_cycles = 0;
  bit          idle_en = 1;
  bit          hold_out = 0;
  bit [31:0]   id_pool[12];

  fragment_hole_reassembly_core u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // monitor both sides, watchdog on stalled traffic
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(func_e'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
        in_beats++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (s_axis_tvalid || sb.expected_beats.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("fragment_hole_reassembly_core test failed");
          $finish;
        end
      end
    end
  end

  // receiver: random stall bursts, long hold-offs on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        m_axis_tready = 0;
        repeat (200) @(negedge clk_i);
        hold_out = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1;
      end
    end
  end

  task automatic send_beat(func_e fn, bit [31:0] id, bit [10:0] off, bit [11:0] len,
                           bit more, bit [7:0] db, bit lb, bit [10:0] ridx);
    int start;
    if (idle_en && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = fn;
    s_axis_tlast  = lb;
    s_axis_tdata  = {5'b0, ridx, db, more, len, off, id};
    start = in_beats;
    do @(negedge clk_i); while (in_beats == start);
  endtask

  // one fragment: len bytes of random payload, last flag on the final byte
  task automatic send_fragment(bit [31:0] id, bit [10:0] off, bit [11:0] len, bit more);
    for (int i = 0; i < len; i++)
      send_beat(FUNC_FRAG, id, off, len, more, 8'($urandom), i == len - 1, 11'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    int pick, len, off;
    bit [31:0] id;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // two fragments complete a packet, then query and reads
    send_fragment(id_pool[0], 0, 3, 1);
    send_fragment(id_pool[0], 3, 2, 0);
    send_beat(FUNC_QUERY, id_pool[0], 0, 1, 0, 0, 0, 0);
    send_beat(FUNC_READ, id_pool[0], 0, 1, 0, 0, 0, 11'd4);
    send_beat(FUNC_READ, id_pool[0], 0, 1, 0, 0, 0, 11'd2047);
    // unknown id on query, read and release
    send_beat(FUNC_QUERY, 32'h1234_5678, 0, 1, 0, 0, 0, 0);
    send_beat(FUNC_READ, 32'h1234_5678, 0, 1, 0, 0, 0, 0);
    send_beat(FUNC_RELEASE, 32'h1234_5678, 0, 1, 0, 0, 0, 0);
    // zero length, byte beyond the buffer, huge length
    send_beat(FUNC_FRAG, id_pool[1], 11'd2047, 12'd0, 1, 8'hff, 1, 0);
    send_beat(FUNC_FRAG, id_pool[1], 11'd2047, 12'd4095, 1, 8'h5a, 0, 0);
    send_beat(FUNC_FRAG, id_pool[1], 11'd2047, 12'd4095, 1, 8'ha5, 1, 0);
    // split holes until the list overflows
    for (int k = 1; k <= 8; k++) send_fragment(id_pool[2], 11'(k * 10), 1, 1);
    // fill the slot table and go two past
    for (int k = 3; k < 9; k++) send_fragment(id_pool[k], 0, 1, 1);
    send_beat(FUNC_FRAG, id_pool[9], 0, 1, 1, 8'h11, 1, 0);
    for (int k = 0; k < 9; k++) send_beat(FUNC_RELEASE, id_pool[k], 0, 1, 0, 0, 0, 0);
    drain();

    while (in_beats < 650) begin
      if (in_beats > 560) idle_en = 0;
      if (in_beats > 150 && in_beats < 160) hold_out = 1;
      if (in_beats > 350 && in_beats < 360) drain();
      id = id_pool[$urandom_range(0, 11)];
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 6);
        off = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
        send_fragment(id, 11'(off), 12'(len), $urandom_range(0, 3) != 0);
      end else if (pick < 75) begin
        send_beat(FUNC_QUERY, id, 0, 1, 0, 0, 0, 0);
      end else if (pick < 87) begin
        send_beat(FUNC_READ, id, 0, 1, 0, 0, 0,
                  $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 30)));
      end else if (pick < 94) begin
        send_beat(FUNC_RELEASE, id, 0, 1, 0, 0, 0, 0);
      end else begin
        // noise: random fields, pool id for fragment bytes so slots can be freed
        pick = $urandom_range(0, 3);
        if (pick != FUNC_FRAG && $urandom_range(0, 1)) id = $urandom;
        send_beat(func_e'(pick), id, 11'($urandom), 12'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom), 11'($urandom));
      end
    end
    drain();

    $display("covered %0d input beats, %0d results checked: %0d ready, %0d hole overflows,",
             in_beats, sb.n_checked, sb.n_ready, sb.n_ovf);
    $display("%0d table-full drops, with back-pressure and a long receiver hold-off", sb.n_full);
    if (sb.errors == 0) begin
      $display("fragment_hole_reassembly_core test passed");
    end else begin
      $display("fragment_hole_reassembly_core test failed");
    end
    $finish;
  end
endmodule
